/* design/assert_macros.svh */
// assertion macros for the design files; only etr_ctrl includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every edge
`define ETR_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define ETR_CHECK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ETR_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ETR_CHECK(lbl, cond, msg)
`define ETR_CHECK_IMPL(lbl, ante, cons, msg)
`define ETR_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/etr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_pkg
// Types, widths and register codes of the epipolar transfer error block.
// ----------------------------------------------------------------------------
package etr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_WIDTH = 16;

  localparam int TAG_IN_W  = 16;
  localparam int TAG_KEEP_W = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
  localparam int COORD_W   = 18;
  localparam int ENT_W     = 18;
  localparam int ROW_W     = 3 * ENT_W;
  localparam int ERR_W     = 32;
  localparam int CFG_IDX_W = 2;

  // exact line coefficient, rounded coefficient
  localparam int PROD_W = ENT_W + COORD_W;
  localparam int ONE_W  = ENT_W + FRAC_BITS;
  localparam int LX_W   = ((PROD_W > ONE_W) ? PROD_W : ONE_W) + 2;
  localparam int LR_W   = LX_W + 1 - FRAC_BITS;

  // residual and its square
  localparam int DP_W  = LR_W + COORD_W;
  localparam int DC_W  = LR_W + FRAC_BITS;
  localparam int D_W   = ((DP_W > DC_W) ? DP_W : DC_W) + 2;
  localparam int SPL_W = (D_W + 1) / 2;
  localparam int SPH_W = D_W - SPL_W;
  localparam int SQ_W  = 2 * D_W;

  // norm, divisor and compare width
  localparam int NORM_W = 2 * LR_W + 1;
  localparam int DIV_W  = NORM_W + FRAC_BITS;
  localparam int CMP_W  = (((DIV_W + ERR_W) > SQ_W) ? (DIV_W + ERR_W) : SQ_W) + 1;

  // pipeline: six front stages, overflow check, one stage per quotient bit, output
  localparam int DIV_FIRST = 7;
  localparam int NSTG      = DIV_FIRST + ERR_W + 1;

  localparam logic [ERR_W-1:0] ERR_SAT = '1;

  typedef logic [2:0][2:0][ENT_W-1:0] mat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_SYM  = 2'd3
  } reg_idx_t;

  // result of one line at the end of the divider
  typedef struct packed {
    logic [ERR_W-1:0] quot;
    logic             sat;
    logic             deg;
  } line_res_t;

endpackage

/* design/etr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_ctrl
// Valid bits of every pipeline stage and the per-stage load enables; a stage
// loads whenever it is empty or the stage after it moves on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module etr_ctrl import etr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [NSTG-1:0] en
);

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] ready;

  // ready chain from the output backwards
  always_comb begin
    ready[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (ready[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign en        = ready;
  assign in_ready  = ready[0];
  assign out_valid = valid_r[NSTG-1];

  `ETR_CHECK_IMPL(a_empty_out_ready, !valid_r[NSTG-1], in_ready, "drained output blocks input")
  `ETR_CHECK_NEXT(a_take_fills, in_valid && in_ready, valid_r[0], "transaction lost at entry")
  `ETR_CHECK_NEXT(a_stall_keeps, valid_r[NSTG-2] && !ready[NSTG-1], valid_r[NSTG-2] && valid_r[NSTG-1], "stalled item dropped")

endmodule

/* design/etr_line.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etr_line
// One epipolar line: coefficients from the matrix and one point, rounding,
// residual at the other point, squared residual and norm, then a restoring
// divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module etr_line import etr_pkg::*; (
  input  logic                      clk,
  input  logic [NSTG-2:0]           en,
  input  mat_t                      coef,
  input  logic signed [COORD_W-1:0] src_x,
  input  logic signed [COORD_W-1:0] src_y,
  input  logic signed [COORD_W-1:0] dst_x,
  input  logic signed [COORD_W-1:0] dst_y,
  output line_res_t                 res
);

  // stage 0: coefficient products
  logic signed [PROD_W-1:0]  p0_r [3];
  logic signed [PROD_W-1:0]  p1_r [3];
  logic signed [ENT_W-1:0]   e2_r [3];
  logic signed [COORD_W-1:0] px0_r, py0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        p0_r[r] <= $signed(coef[r][0]) * src_x;
        p1_r[r] <= $signed(coef[r][1]) * src_y;
        e2_r[r] <= $signed(coef[r][2]);
      end
      px0_r <= dst_x;
      py0_r <= dst_y;
    end
  end

  // stage 1: exact sum and round half up
  logic signed [LR_W-1:0]    lr_nxt [3];
  logic signed [LR_W-1:0]    lr_r   [3];
  logic signed [COORD_W-1:0] px1_r, py1_r;

  always_comb begin
    logic signed [LX_W:0] s;
    for (int r = 0; r < 3; r++) begin
      s = (LX_W+1)'(p0_r[r]) + (LX_W+1)'(p1_r[r])
        + ((LX_W+1)'(e2_r[r]) <<< FRAC_BITS)
        + ((LX_W+1)'(1) << (FRAC_BITS - 1));
      lr_nxt[r] = s[LX_W:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) lr_r[r] <= lr_nxt[r];
      px1_r <= px0_r;
      py1_r <= py0_r;
    end
  end

  // stage 2: residual terms and squared coefficients
  logic signed [DP_W-1:0]   mx_r, my_r;
  logic signed [LR_W-1:0]   c2_r;
  logic signed [2*LR_W-1:0] sa_r, sb_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mx_r <= lr_r[0] * px1_r;
      my_r <= lr_r[1] * py1_r;
      c2_r <= lr_r[2];
      sa_r <= lr_r[0] * lr_r[0];
      sb_r <= lr_r[1] * lr_r[1];
    end
  end

  // stage 3: residual magnitude and norm
  logic signed [D_W-1:0] d_nxt;
  logic [D_W-1:0]        ud_r;
  logic [NORM_W-1:0]     norm3_r;

  assign d_nxt = D_W'(mx_r) + D_W'(my_r) + (D_W'(c2_r) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ud_r    <= d_nxt[D_W-1] ? D_W'(-d_nxt) : D_W'(d_nxt);
      norm3_r <= NORM_W'(unsigned'(sa_r)) + NORM_W'(unsigned'(sb_r));
    end
  end

  // stage 4: partial products of the square
  logic [2*SPH_W-1:0]     hh_r;
  logic [SPH_W+SPL_W-1:0] hl_r;
  logic [2*SPL_W-1:0]     ll_r;
  logic [NORM_W-1:0]      norm4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh_r    <= ud_r[D_W-1:SPL_W] * ud_r[D_W-1:SPL_W];
      hl_r    <= ud_r[D_W-1:SPL_W] * ud_r[SPL_W-1:0];
      ll_r    <= ud_r[SPL_W-1:0] * ud_r[SPL_W-1:0];
      norm4_r <= norm3_r;
    end
  end

  // stage 5: square, divisor and zero norm
  logic [SQ_W-1:0]  sq5_r;
  logic [DIV_W-1:0] div5_r;
  logic             deg5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sq5_r  <= (SQ_W'(hh_r) << (2 * SPL_W)) + (SQ_W'(hl_r) << (SPL_W + 1)) + SQ_W'(ll_r);
      div5_r <= {norm4_r, {FRAC_BITS{1'b0}}};
      deg5_r <= (norm4_r == '0);
    end
  end

  // stage 6 onwards: overflow check, then one quotient bit a stage
  logic [SQ_W-1:0]  rem_r  [ERR_W+1];
  logic [DIV_W-1:0] div_r  [ERR_W+1];
  logic [ERR_W-1:0] quot_r [ERR_W+1];
  logic             sat_r  [ERR_W+1];
  logic             deg_r  [ERR_W+1];

  always_ff @(posedge clk) begin
    if (en[DIV_FIRST-1]) begin
      rem_r[0]  <= sq5_r;
      div_r[0]  <= div5_r;
      quot_r[0] <= '0;
      sat_r[0]  <= (CMP_W'(sq5_r) >= (CMP_W'(div5_r) << ERR_W));
      deg_r[0]  <= deg5_r;
    end
  end

  for (genvar j = 0; j < ERR_W; j++) begin : g_div
    localparam int BIT = ERR_W - 1 - j;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign trial = CMP_W'(div_r[j]) << BIT;
    assign ge    = (CMP_W'(rem_r[j]) >= trial);

    always_ff @(posedge clk) begin
      if (en[DIV_FIRST+j]) begin
        rem_r[j+1]  <= ge ? (rem_r[j] - trial[SQ_W-1:0]) : rem_r[j];
        div_r[j+1]  <= div_r[j];
        quot_r[j+1] <= quot_r[j] | (ERR_W'(ge) << BIT);
        sat_r[j+1]  <= sat_r[j];
        deg_r[j+1]  <= deg_r[j];
      end
    end
  end

  assign res.quot = quot_r[ERR_W];
  assign res.sat  = sat_r[ERR_W];
  assign res.deg  = deg_r[ERR_W];

endmodule

/* design/epipolar_transfer_error.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epipolar_transfer_error
// Squared symmetric epipolar distance of a point correspondence against a
// fundamental matrix held in configuration registers.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle unless out_ready stalls the
// pipeline; its result passes through six stages of line, residual and square
// arithmetic, one overflow check stage and the 32-stage restoring divider, one
// quotient bit per stage, followed by the output register. Both lines are worked
// out in parallel units. Configuration writes are taken at any time (cfg_ready
// is always high) but must only be issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module epipolar_transfer_error import etr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [ROW_W-1:0]          cfg_data,
  // correspondences
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TAG_IN_W-1:0]       in_point_index,
  input  logic signed [COORD_W-1:0] in_first_x,
  input  logic signed [COORD_W-1:0] in_first_y,
  input  logic signed [COORD_W-1:0] in_second_x,
  input  logic signed [COORD_W-1:0] in_second_y,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [TAG_IN_W-1:0]       out_tag_out,
  output logic [ERR_W-1:0]          out_squared_error,
  output logic                      out_error_side,
  output logic                      out_degenerate
);

  // configuration registers
  logic [ROW_W-1:0] row_r [3];
  logic             sym_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
      sym_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0: row_r[0] <= cfg_data;
        REG_ROW1: row_r[1] <= cfg_data;
        REG_ROW2: row_r[2] <= cfg_data;
        REG_SYM:  sym_r    <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // matrix for the image-2 line and its transpose for the image-1 line
  mat_t fwd, bwd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        fwd[r][c] = row_r[r][c*ENT_W +: ENT_W];
        bwd[r][c] = row_r[c][r*ENT_W +: ENT_W];
      end
    end
  end

  // stage control
  logic [NSTG-1:0] en;

  etr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  // line units
  line_res_t res2, res1;

  etr_line u_line2 (
    .clk   (clk),
    .en    (en[NSTG-2:0]),
    .coef  (fwd),
    .src_x (in_first_x),
    .src_y (in_first_y),
    .dst_x (in_second_x),
    .dst_y (in_second_y),
    .res   (res2)
  );

  etr_line u_line1 (
    .clk   (clk),
    .en    (en[NSTG-2:0]),
    .coef  (bwd),
    .src_x (in_second_x),
    .src_y (in_second_y),
    .dst_x (in_first_x),
    .dst_y (in_first_y),
    .res   (res1)
  );

  // tag and mode travel alongside the item
  logic [TAG_KEEP_W-1:0] tag_pipe_r [NSTG-1];
  logic                  sym_pipe_r [NSTG-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_pipe_r[0] <= in_point_index[TAG_KEEP_W-1:0];
      sym_pipe_r[0] <= sym_r;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) begin
        tag_pipe_r[k] <= tag_pipe_r[k-1];
        sym_pipe_r[k] <= sym_pipe_r[k-1];
      end
    end
  end

  // final pick of the larger error in symmetric mode; a tie keeps the image-2 error
  logic [ERR_W-1:0] err2, err1;
  logic             pick1;

  assign err2  = (res2.deg || res2.sat) ? ERR_SAT : res2.quot;
  assign err1  = (res1.deg || res1.sat) ? ERR_SAT : res1.quot;
  assign pick1 = sym_pipe_r[NSTG-2] && (err1 > err2);

  // output register
  logic [TAG_KEEP_W-1:0] tag_r;
  logic [ERR_W-1:0]      err_r;
  logic                  side_r;
  logic                  deg_r;

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      tag_r  <= tag_pipe_r[NSTG-2];
      err_r  <= pick1 ? err1 : err2;
      side_r <= !pick1;
      deg_r  <= res2.deg || (sym_pipe_r[NSTG-2] && res1.deg);
    end
  end

  assign out_tag_out       = TAG_IN_W'(tag_r);
  assign out_squared_error = err_r;
  assign out_error_side    = side_r;
  assign out_degenerate    = deg_r;

endmodule

/* tb/epipolar_transfer_error_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epipolar_transfer_error_test
// Self-checking bench for the epipolar transfer error block. A directed table
// covers field extremes, degenerate lines and equal errors. Random phases
// follow, each with its own matrix, mode and idling pattern. Other than typed
// rows, every result is compared with the bench's fixed-point error predictor.
// ----------------------------------------------------------------------------
module epipolar_transfer_error_test;
  import etr_pkg::*;

  typedef struct {
    logic [TAG_IN_W-1:0]       tag;
    logic signed [COORD_W-1:0] x1, y1, x2, y2;
    bit                        typed;
    logic [ERR_W-1:0]          err;
    logic                      side, deg;
  } corr_row_t;

  typedef struct {
    logic [TAG_IN_W-1:0] tag;
    logic [ERR_W-1:0]    err;
    logic                side, deg;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TAG_IN_W-1:0] in_point_index = '0;
  logic signed [COORD_W-1:0] in_first_x = '0, in_first_y = '0;
  logic signed [COORD_W-1:0] in_second_x = '0, in_second_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TAG_IN_W-1:0] out_tag_out;
  logic [ERR_W-1:0] out_squared_error;
  logic out_error_side, out_degenerate;

  // bench copy of the configuration
  logic [ROW_W-1:0] f_row [3];
  logic             sym_on;

  dist_res_t dist_q[$];
  corr_row_t dir_tab[12];
  int  mismatches = 0;
  int  send_idle = 0;
  int  recv_stall = 0;

  epipolar_transfer_error uut (.*);

  always #6 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic longint f_entry(int r, int c);
    return longint'($signed(f_row[r][ENT_W*c +: ENT_W]));
  endfunction

  // squared distance of a point from a line given at 2F fraction bits
  function automatic logic [ERR_W-1:0] line_dist(longint a, longint b, longint c,
                                                 longint px, longint py,
                                                 inout bit deg);
    longint ar, br, cr, d;
    logic [127:0] ua, ub, ud, nrm, q;
    ar = (a + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    br = (b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    cr = (c + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    d  = ar * px + br * py + (cr <<< FRAC_BITS);
    ua = (ar < 0) ? -ar : ar;
    ub = (br < 0) ? -br : br;
    ud = (d < 0) ? -d : d;
    nrm = ua * ua + ub * ub;
    if (nrm == 0) begin
      deg = 1'b1;
      return ERR_SAT;
    end
    q = (ud * ud) / (nrm << FRAC_BITS);
    if ((q >> ERR_W) != 0) return ERR_SAT;
    return q[ERR_W-1:0];
  endfunction

  function automatic dist_res_t predict_dist(corr_row_t t);
    dist_res_t r;
    bit deg;
    longint one, xa, ya, xb, yb;
    logic [ERR_W-1:0] e1;
    deg = 1'b0;
    one = longint'(1) <<< FRAC_BITS;
    xa = t.x1; ya = t.y1; xb = t.x2; yb = t.y2;
    r.tag = t.tag;
    r.side = 1'b1;
    r.err = line_dist(f_entry(0, 0) * xa + f_entry(0, 1) * ya + f_entry(0, 2) * one,
                      f_entry(1, 0) * xa + f_entry(1, 1) * ya + f_entry(1, 2) * one,
                      f_entry(2, 0) * xa + f_entry(2, 1) * ya + f_entry(2, 2) * one,
                      xb, yb, deg);
    if (sym_on) begin
      e1 = line_dist(f_entry(0, 0) * xb + f_entry(1, 0) * yb + f_entry(2, 0) * one,
                     f_entry(0, 1) * xb + f_entry(1, 1) * yb + f_entry(2, 1) * one,
                     f_entry(0, 2) * xb + f_entry(1, 2) * yb + f_entry(2, 2) * one,
                     xa, ya, deg);
      // image-1 error wins only when strictly larger
      if (e1 > r.err) begin
        r.err = e1;
        r.side = 1'b0;
      end
    end
    r.deg = deg;
    return r;
  endfunction

  function automatic corr_row_t mk_row(logic [15:0] tag, logic [17:0] x1, logic [17:0] y1,
                                       logic [17:0] x2, logic [17:0] y2, bit typed);
    corr_row_t t;
    t.tag = tag; t.x1 = x1; t.y1 = y1; t.x2 = x2; t.y2 = y2;
    t.typed = typed;
    // only the all-zero matrix rows are typed: both lines degenerate
    t.err = ERR_SAT; t.side = 1'b1; t.deg = 1'b1;
    return t;
  endfunction

  // random signed value of random magnitude
  function automatic logic [COORD_W-1:0] rand_s18();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    return v >>> $urandom_range(COORD_W - 1);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [ROW_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SYM) sym_on = val[0];
    else f_row[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one correspondence transaction; prediction at acceptance
  task automatic send_corr(corr_row_t t, bit use_typed);
    dist_res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_point_index <= t.tag;
    in_first_x     <= t.x1;
    in_first_y     <= t.y1;
    in_second_x    <= t.x2;
    in_second_y    <= t.y2;
    do @(posedge clk); while (!in_ready);
    if (use_typed) begin
      r.tag = t.tag; r.err = t.err; r.side = t.side; r.deg = t.deg;
    end else begin
      r = predict_dist(t);
    end
    dist_q = {dist_q, r};
    @(negedge clk);
  endtask

  // quiet pipeline before a configuration change
  task automatic drain();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    dist_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result tag %h err %h", out_tag_out, out_squared_error);
      end else begin
        e = dist_q.pop_front();
        if (out_tag_out !== e.tag || out_squared_error !== e.err ||
            out_error_side !== e.side || out_degenerate !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp tag %h err %h side %b deg %b, got %h %h %b %b",
                     e.tag, e.err, e.side, e.deg, out_tag_out, out_squared_error,
                     out_error_side, out_degenerate);
        end
      end
    end
  end

  initial begin
    logic [ENT_W-1:0] ent [3][3];
    corr_row_t t;
    f_row[0] = '0; f_row[1] = '0; f_row[2] = '0;
    sym_on = 1'b1;

    // extremes, degenerate under the reset matrix, equal errors at the origin
    dir_tab[0]  = mk_row(16'h0000, 18'h00000, 18'h00000, 18'h00000, 18'h00000, 1);
    dir_tab[1]  = mk_row(16'hFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 1);
    dir_tab[2]  = mk_row(16'h5555, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 1);
    dir_tab[3]  = mk_row(16'hAAAA, 18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 1);
    dir_tab[4]  = mk_row(16'h8000, 18'h2AAAA, 18'h15555, 18'h3FFFF, 18'h00001, 1);
    dir_tab[5]  = mk_row(16'h0001, 18'h15555, 18'h2AAAA, 18'h00001, 18'h3FFFF, 1);
    dir_tab[6]  = mk_row(16'h0010, 18'h00000, 18'h00000, 18'h10000, 18'h10000, 0);
    dir_tab[7]  = mk_row(16'h0011, 18'h10000, 18'h10000, 18'h00000, 18'h00000, 0);
    dir_tab[8]  = mk_row(16'h0012, 18'h10000, 18'h08000, 18'h30000, 18'h04000, 0);
    dir_tab[9]  = mk_row(16'h0013, 18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000, 0);
    dir_tab[10] = mk_row(16'h0014, 18'h00100, 18'h3FF00, 18'h00200, 18'h00080, 0);
    dir_tab[11] = mk_row(16'h0015, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass under the reset configuration
    foreach (dir_tab[i]) send_corr(dir_tab[i], dir_tab[i].typed);
    drain();

    // skew matrix at one half: a degenerate line in one image only
    write_reg(REG_ROW0, {18'd0, -18'sd32768, 18'd0});
    write_reg(REG_ROW1, {18'd0, 18'd0, 18'd32768});
    write_reg(REG_ROW2, '0);
    foreach (dir_tab[i]) send_corr(dir_tab[i], 1'b0);
    drain();

    // random phases, each with its own matrix, mode and idling
    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          ent[r][c] = (p == 0) ? 18'h1FFFF : (p == 1) ? 18'h20000 : rand_s18();
      for (int r = 0; r < 3; r++)
        write_reg(reg_idx_t'(r), {ent[r][2], ent[r][1], ent[r][0]});
      write_reg(REG_SYM, ROW_W'(p % 2 == 0));
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      for (int n = 0; n < 115; n++) begin
        t = mk_row(16'($urandom), rand_s18(), rand_s18(), rand_s18(), rand_s18(), 0);
        send_corr(t, 1'b0);
      end
      drain();
    end

    send_idle = 0;
    recv_stall = 0;
    if (mismatches == 0 && dist_q.size() == 0)
      $display("[epipolar_transfer_error] OK");
    else
      $display("[epipolar_transfer_error] ERROR");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("[epipolar_transfer_error] ERROR");
    $finish;
  end

endmodule
